// ===== rtl/core/nafmt_pkg.sv =====
// package for the number to ascii formatter: payload types, control structs, character codes
`timescale 1ns / 1ps
package nafmt_pkg;

  localparam int WORD_W     = 32;
  localparam int CHAR_W     = 7;
  localparam int NIB_W      = 4;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = DEC_DIGITS * NIB_W;
  localparam int HEX_CHARS  = 2 + WORD_W / NIB_W;
  localparam int POS_W      = 4;
  localparam int CONV_STEPS = WORD_W;
  localparam int STEP_W     = $clog2(CONV_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 7'h46;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] value;
  } nafmt_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
  } nafmt_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic find;
    logic emit;
  } nafmt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_char;
  } nafmt_stat_t;

  function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib > 4'd9) begin
      ch = CHAR_UPPER_A + CHAR_W'(nib) - CHAR_W'(10);
    end else begin
      ch = CHAR_ZERO + CHAR_W'(nib);
    end
    return ch;
  endfunction

endpackage

// ===== rtl/core/nafmt_ctrl.sv =====
// controller state machine: load, binary to bcd conversion, lead digit search, character emit
`timescale 1ns / 1ps
module nafmt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                num_valid,
  input  logic                op,
  output logic                num_ready,
  input  nafmt_pkg::nafmt_stat_t stat,
  output nafmt_pkg::nafmt_cmd_t  cmd
);
  import nafmt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_FIND = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;

  assign num_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (num_valid) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          state_next    = (op == OP_HEX) ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(CONV_STEPS - 1)) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_char) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

// ===== rtl/core/nafmt_datapath.sv =====
// datapath: magnitude and bcd shift registers, character select and output register
`timescale 1ns / 1ps
module nafmt_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  nafmt_pkg::nafmt_in_t   num,
  input  nafmt_pkg::nafmt_cmd_t  cmd,
  output nafmt_pkg::nafmt_stat_t stat,
  output logic                   txt_valid,
  input  logic                   txt_ready,
  output nafmt_pkg::nafmt_out_t  txt
);
  import nafmt_pkg::*;

  logic              mode;
  logic              sign_pend;
  logic [WORD_W-1:0] work;
  logic [BCD_W-1:0]  bcd;
  logic [POS_W-1:0]  pos;

  logic              neg_in;
  logic [BCD_W-1:0]  bcd_adj;
  logic [POS_W-1:0]  lead_pos;
  logic [NIB_W-1:0]  digit;
  logic [CHAR_W-1:0] ch;
  logic              last_c;

  assign neg_in = (num.op == OP_DEC) && num.value[WORD_W-1];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i*NIB_W +: NIB_W] >= 4'd5) begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W] + 4'd3;
      end else begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W];
      end
    end
  end

  // highest nonzero digit, zero gives the units place
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i*NIB_W +: NIB_W] != '0) begin
        lead_pos = POS_W'(i);
      end
    end
  end

  assign digit = bcd[{pos, 2'b00} +: NIB_W];

  always_comb begin
    if (mode == OP_HEX) begin
      last_c = (pos == POS_W'(HEX_CHARS - 1));
      if (pos == POS_W'(0)) begin
        ch = CHAR_ZERO;
      end else if (pos == POS_W'(1)) begin
        ch = CHAR_X;
      end else begin
        ch = nib_to_ascii(work[WORD_W-1 -: NIB_W]);
      end
    end else begin
      last_c = !sign_pend && (pos == '0);
      ch     = sign_pend ? CHAR_MINUS : nib_to_ascii(digit);
    end
  end

  assign stat.out_free  = !txt_valid || txt_ready;
  assign stat.last_char = last_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode      <= num.op;
      sign_pend <= neg_in;
      work      <= neg_in ? (WORD_W'(0) - num.value) : num.value;
      bcd       <= '0;
      pos       <= '0;
    end else if (cmd.step) begin
      bcd  <= {bcd_adj[BCD_W-2:0], work[WORD_W-1]};
      work <= {work[WORD_W-2:0], 1'b0};
    end else if (cmd.find) begin
      pos <= lead_pos;
    end else if (cmd.emit) begin
      if (mode == OP_HEX) begin
        pos <= pos + POS_W'(1);
        if (pos >= POS_W'(2)) begin
          work <= {work[WORD_W-NIB_W-1:0], NIB_W'(0)};
        end
      end else if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        pos <= pos - POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      txt.ascii_char <= ch;
      txt.last       <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      txt_valid <= 1'b0;
    end else if (cmd.emit) begin
      txt_valid <= 1'b1;
    end else if (txt_ready) begin
      txt_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/number_to_ascii_formatter.sv =====
// top level of the number to ascii formatter: controller, datapath and assertions
// hex: no conversion; characters are registered from the loaded word, one per cycle
//   while the output is not stalled, 10 characters in all
// decimal: shift-add-3 conversion and then a lead digit search, then one character per
//   cycle while the output is not stalled, n characters per item (n up to 11)
// the last character sits in the output register while the next input is taken
// synchronous active-high reset clears the state machine and the output valid
`timescale 1ns / 1ps
module number_to_ascii_formatter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  num_valid,
  output logic                  num_ready,
  input  nafmt_pkg::nafmt_in_t  num,
  output logic                  txt_valid,
  input  logic                  txt_ready,
  output nafmt_pkg::nafmt_out_t txt
);
  import nafmt_pkg::*;

  nafmt_cmd_t  cmd;
  nafmt_stat_t stat;

  nafmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .op        (num.op),
    .num_ready (num_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nafmt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .num       (num),
    .cmd       (cmd),
    .stat      (stat),
    .txt_valid (txt_valid),
    .txt_ready (txt_ready),
    .txt       (txt)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (num_valid && num_ready) |=> !num_ready)
    else $error("input accepted again while a number is in progress");

  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    txt_valid |-> ((txt.ascii_char >= CHAR_ZERO && txt.ascii_char <= CHAR_NINE) ||
                   (txt.ascii_char >= CHAR_UPPER_A && txt.ascii_char <= CHAR_UPPER_F) ||
                   txt.ascii_char == CHAR_X || txt.ascii_char == CHAR_MINUS))
    else $error("character outside the number alphabet");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(num_ready) |-> (txt_valid && txt.last))
    else $error("returned to idle without a last character pending");

endmodule

// ===== dv/tb_number_to_ascii_formatter.sv =====
// testbench for number_to_ascii_formatter: directed table and random words, scored per character
`timescale 1ns / 1ps
module tb_number_to_ascii_formatter;
  import nafmt_pkg::*;

  localparam int RANDOM_WORDS = 360;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 64;

  typedef struct {
    logic              op;
    logic [WORD_W-1:0] value;
    string             text;
  } word_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       num_valid = 1'b0;
  logic       num_ready;
  nafmt_in_t  num = '0;
  logic       txt_valid;
  logic       txt_ready = 1'b0;
  nafmt_out_t txt;

  nafmt_out_t char_q[$];
  int         err_count = 0;
  int         rx_count = 0;
  bit         rx_holding = 1'b0;
  bit         tx_calm = 1'b0;
  word_row_t  word_rows[20];

  number_to_ascii_formatter u_top (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .txt_valid (txt_valid),
    .txt_ready (txt_ready),
    .txt       (txt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_text(input string text);
    nafmt_out_t c;
    byte        b;
    for (int k = 0; k < text.len(); k++) begin
      b            = text[k];
      c.ascii_char = b[CHAR_W-1:0];
      c.last       = (k == text.len() - 1);
      char_q.push_back(c);
    end
  endtask

  // expected characters of one word, pushed in order
  task automatic predict_text(input logic op, input logic [WORD_W-1:0] value);
    logic [CHAR_W-1:0] chars[$];
    logic [WORD_W-1:0] mag;
    logic [NIB_W-1:0]  nib;
    nafmt_out_t        c;
    if (op == OP_HEX) begin
      chars.push_back(CHAR_ZERO);
      chars.push_back(CHAR_X);
      for (int sh = WORD_W - NIB_W; sh >= 0; sh -= NIB_W) begin
        nib = value[sh +: NIB_W];
        if (nib > 4'd9) chars.push_back(CHAR_UPPER_A + CHAR_W'(nib - 4'd10));
        else chars.push_back(CHAR_ZERO + CHAR_W'(nib));
      end
    end else begin
      mag = value[WORD_W-1] ? -value : value;
      do begin
        chars.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (value[WORD_W-1]) chars.push_front(CHAR_MINUS);
    end
    foreach (chars[k]) begin
      c.ascii_char = chars[k];
      c.last       = (k == chars.size() - 1);
      char_q.push_back(c);
    end
  endtask

  task automatic offer_word(input logic op, input logic [WORD_W-1:0] value, input string text);
    int gap;
    gap = (tx_calm || rx_holding) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      num_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num_valid  <= 1'b1;
    num.op     <= op;
    num.value  <= value;
    do @(posedge clk); while (!num_ready);
    if (text.len() != 0) queue_text(text);
    else predict_text(op, value);
  endtask

  task automatic drain_text();
    num_valid <= 1'b0;
    do @(posedge clk); while (char_q.size() != 0);
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] p;
    p = 1;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 1000);
      2: v = 32'd0 - $urandom_range(1, 1000);
      3: begin
        repeat ($urandom_range(1, 9)) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
        v = v + $urandom_range(0, 4) - 2;
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    word_rows = '{
      '{OP_DEC, 32'd0,          "0"},
      '{OP_DEC, 32'd1,          "1"},
      '{OP_DEC, 32'd9,          "9"},
      '{OP_DEC, 32'd10,         "10"},
      '{OP_DEC, 32'hFFFF_FFFF,  "-1"},
      '{OP_DEC, 32'hFFFF_FFF6,  "-10"},
      '{OP_DEC, 32'h7FFF_FFFF,  "2147483647"},
      '{OP_DEC, 32'h8000_0000,  "-2147483648"},
      '{OP_DEC, 32'h8000_0001,  "-2147483647"},
      '{OP_DEC, 32'd1000000000, "1000000000"},
      '{OP_DEC, 32'd999999999,  "999999999"},
      '{OP_DEC, 32'd12345,      ""},
      '{OP_DEC, 32'hDEAD_BEEF,  ""},
      '{OP_HEX, 32'h0000_0000,  "0x00000000"},
      '{OP_HEX, 32'hFFFF_FFFF,  "0xFFFFFFFF"},
      '{OP_HEX, 32'h8000_0000,  "0x80000000"},
      '{OP_HEX, 32'h0123_4567,  "0x01234567"},
      '{OP_HEX, 32'h89AB_CDEF,  "0x89ABCDEF"},
      '{OP_HEX, 32'h0000_000F,  "0x0000000F"},
      '{OP_HEX, 32'hA5A5_5A5A,  ""}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (word_rows[i]) offer_word(word_rows[i].op, word_rows[i].value, word_rows[i].text);
    drain_text();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      tx_calm = ((i / 40) % 3 == 2);
      if (i == RANDOM_WORDS / 2) drain_text();
      offer_word($urandom_range(0, 1) ? OP_HEX : OP_DEC, pick_value(), "");
    end
    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: per-character stall, calm stretches, one long hold-off
  initial begin
    int  stall;
    bit  hold_done;
    hold_done = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_count >= HOLD_AT && !hold_done) begin
        hold_done  = 1'b1;
        rx_holding = 1'b1;
        txt_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else begin
        stall = ((rx_count / 50) % 4 == 1) ? 0 : $urandom_range(0, 13);
        if (stall != 0) begin
          txt_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      txt_ready <= 1'b1;
      do @(posedge clk); while (!txt_valid);
      rx_count++;
    end
  end

  always @(posedge clk) begin
    nafmt_out_t want;
    if (!rst && txt_valid && txt_ready) begin
      if (char_q.size() == 0) begin
        $error("unexpected transfer: ascii_char %h last %b", txt.ascii_char, txt.last);
        err_count++;
      end else begin
        want = char_q.pop_front();
        if (txt.ascii_char !== want.ascii_char) begin
          $error("ascii_char expected %h actual %h", want.ascii_char, txt.ascii_char);
          err_count++;
        end
        if (txt.last !== want.last) begin
          $error("last expected %b actual %b", want.last, txt.last);
          err_count++;
        end
      end
    end
  end

endmodule
